/* hw/rtl/dupd_pkg.sv */
`timescale 1ns / 1ps
package dupd_pkg;

  localparam int FifoDepth = 4;
  localparam int FifoAw    = $clog2(FifoDepth);
  localparam int FifoCntW  = FifoAw + 1;

  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharPlus    = 8'h2b;
  localparam logic [7:0] CharMinus   = 8'h2d;
  localparam logic [7:0] CharSlash   = 8'h2f;
  localparam logic [7:0] CharPercent = 8'h25;
  localparam logic [7:0] CharPad     = 8'h3d;
  localparam logic [7:0] CharTab     = 8'h09;
  localparam logic [7:0] CharCr      = 8'h0d;

  // one queue entry: all results caused by one input character
  typedef struct packed {
    logic [23:0] data;
    logic [1:0]  last_idx;
    logic        byte_valid;
    logic        decode_error;
    logic        is_last;
  } dupd_entry_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] value;
  } dupd_sextet_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } dupd_hex_t;

  function automatic dupd_sextet_t sextet_of(input logic [7:0] c);
    dupd_sextet_t r;
    r.ok    = 1'b1;
    r.value = 6'd0;
    if (c == CharPlus) begin
      r.value = 6'd62;
    end else if (c == CharSlash) begin
      r.value = 6'd63;
    end else if (c == CharPad) begin
      r.value = 6'd0;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 6'(c + 8'd4);
    end else if (c >= 8'h41 && c <= 8'h5a) begin
      r.value = 6'(c - 8'd65);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r.value = 6'(c - 8'd71);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic dupd_hex_t hex_of(input logic [7:0] c);
    dupd_hex_t r;
    r.ok    = 1'b1;
    r.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.value = 4'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.value = 4'(c - 8'h61 + 8'd10);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CharSpace) || (c >= CharTab && c <= CharCr);
  endfunction

endpackage

/* hw/rtl/dupd_front.sv */
`timescale 1ns / 1ps
module dupd_front import dupd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_char_i,
  input  logic        is_final_i,
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output dupd_entry_t push_entry_o
);

  localparam logic [1:0] EscIdle = 2'd0;
  localparam logic [1:0] EscLead = 2'd1;
  localparam logic [1:0] EscHex  = 2'd2;
  localparam logic [1:0] EscSign = 2'd3;

  localparam logic [3:0] LeadNone  = 4'd0;
  localparam logic [3:0] LeadPlus  = 4'd1;
  localparam logic [3:0] LeadMinus = 4'd2;

  logic        mode_q;
  logic [17:0] acc_q, acc_d;
  logic [1:0]  gc_q, gc_d;
  logic [1:0]  pad_q, pad_d, pad_new;
  logic        err_q, err_d;
  logic [1:0]  phase_q, phase_d;
  logic [3:0]  hn_q, hn_d;
  logic        stop_q, stop_d;

  logic         accept;
  logic         has_res;
  dupd_entry_t  entry;
  dupd_sextet_t sx;
  dupd_hex_t    hx;
  logic [7:0]   esc_val;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = push_ready_i;

  always_comb begin
    sx = sextet_of(in_char_i);
    hx = hex_of(in_char_i);

    if (phase_q == EscHex) begin
      esc_val = hx.ok ? {hn_q, hx.value} : {4'd0, hn_q};
    end else if (!hx.ok || hn_q == LeadNone) begin
      esc_val = 8'd0;
    end else if (hn_q == LeadMinus) begin
      esc_val = 8'd0 - {4'd0, hx.value};
    end else begin
      esc_val = {4'd0, hx.value};
    end

    acc_d   = acc_q;
    gc_d    = gc_q;
    pad_d   = pad_q;
    err_d   = err_q;
    phase_d = phase_q;
    hn_d    = hn_q;
    stop_d  = stop_q;
    pad_new = pad_q;
    has_res = 1'b0;
    entry   = '0;

    if (mode_q) begin
      if (!err_q && in_char_i != CharSpace) begin
        if (!sx.ok) begin
          err_d              = 1'b1;
          has_res            = 1'b1;
          entry.decode_error = 1'b1;
        end else begin
          if (in_char_i == CharPad && pad_q != 2'd3) begin
            pad_new = pad_q + 2'd1;
          end
          pad_d = pad_new;
          if (gc_q != 2'd3) begin
            acc_d = {acc_q[11:0], sx.value};
            gc_d  = gc_q + 2'd1;
          end else begin
            // group complete: three bytes less one per pad
            acc_d = '0;
            gc_d  = 2'd0;
            pad_d = 2'd0;
            if (pad_new != 2'd3) begin
              has_res          = 1'b1;
              entry.data       = {acc_q, sx.value};
              entry.last_idx   = 2'd2 - pad_new;
              entry.byte_valid = 1'b1;
            end
          end
        end
      end
      if (is_final_i) begin
        if (has_res) begin
          entry.is_last = 1'b1;
        end else begin
          has_res            = 1'b1;
          entry.decode_error = err_d || (gc_d != 2'd0);
          entry.is_last      = 1'b1;
        end
      end
    end else begin
      case (phase_q)
        EscIdle: begin
          if (!stop_q) begin
            if (in_char_i == CharSlash) begin
              stop_d = 1'b1;
            end else if (in_char_i == CharPercent) begin
              phase_d = EscLead;
              if (is_final_i) begin
                has_res          = 1'b1;
                entry.byte_valid = 1'b1;
              end
            end else begin
              has_res          = 1'b1;
              entry.byte_valid = 1'b1;
              entry.data       = {in_char_i, 16'd0};
            end
          end
        end
        EscLead: begin
          if (hx.ok) begin
            phase_d = EscHex;
            hn_d    = hx.value;
          end else begin
            phase_d = EscSign;
            if (is_space(in_char_i) || in_char_i == CharPlus) begin
              hn_d = LeadPlus;
            end else if (in_char_i == CharMinus) begin
              hn_d = LeadMinus;
            end else begin
              hn_d = LeadNone;
            end
          end
          if (is_final_i) begin
            has_res          = 1'b1;
            entry.byte_valid = 1'b1;
            entry.data       = {(hx.ok ? {4'd0, hx.value} : 8'd0), 16'd0};
          end
        end
        default: begin
          has_res          = 1'b1;
          entry.byte_valid = 1'b1;
          entry.data       = {esc_val, 16'd0};
          phase_d          = EscIdle;
          hn_d             = 4'd0;
        end
      endcase
      if (is_final_i) begin
        has_res       = 1'b1;
        entry.is_last = 1'b1;
      end
    end

    // end of stream clears the stream state of both modes
    if (is_final_i) begin
      acc_d   = '0;
      gc_d    = 2'd0;
      pad_d   = 2'd0;
      err_d   = 1'b0;
      phase_d = EscIdle;
      hn_d    = 4'd0;
      stop_d  = 1'b0;
    end
  end

  assign push_valid_o = in_valid_i && has_res;
  assign push_entry_o = entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      acc_q   <= '0;
      gc_q    <= 2'd0;
      pad_q   <= 2'd0;
      err_q   <= 1'b0;
      phase_q <= EscIdle;
      hn_q    <= 4'd0;
      stop_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (accept) begin
        acc_q   <= acc_d;
        gc_q    <= gc_d;
        pad_q   <= pad_d;
        err_q   <= err_d;
        phase_q <= phase_d;
        hn_q    <= hn_d;
        stop_q  <= stop_d;
      end
    end
  end

endmodule

/* hw/rtl/dupd_fifo.sv */
`timescale 1ns / 1ps
module dupd_fifo import dupd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  dupd_entry_t in_entry_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output dupd_entry_t out_entry_o
);

  dupd_entry_t         mem_q [FifoDepth];
  logic [FifoAw-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] cnt_q;
  logic                push, pop;

  assign in_ready_o  = cnt_q != FifoCntW'(FifoDepth);
  assign out_valid_o = cnt_q != '0;
  assign out_entry_o = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + FifoAw'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FifoAw'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + FifoCntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - FifoCntW'(1);
      end
    end
  end

endmodule

/* hw/rtl/dupd_back.sv */
`timescale 1ns / 1ps
module dupd_back import dupd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  dupd_entry_t in_entry_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic        decode_error_o,
  output logic        is_last_o
);

  logic [1:0] idx_q;
  logic       valid_q;
  logic [7:0] byte_q;
  logic       bv_q, err_q, last_q;
  logic       load, at_end;
  logic [7:0] sel_byte;

  assign load       = in_valid_i && (!valid_q || out_ready_i);
  assign at_end     = idx_q == in_entry_i.last_idx;
  assign in_ready_o = load && at_end;

  always_comb begin
    case (idx_q)
      2'd0:    sel_byte = in_entry_i.data[23:16];
      2'd1:    sel_byte = in_entry_i.data[15:8];
      default: sel_byte = in_entry_i.data[7:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= sel_byte;
      bv_q   <= in_entry_i.byte_valid;
      err_q  <= in_entry_i.decode_error;
      last_q <= in_entry_i.is_last && at_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= at_end ? 2'd0 : idx_q + 2'd1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = valid_q;
  assign out_byte_o     = byte_q;
  assign byte_valid_o   = bv_q;
  assign decode_error_o = err_q;
  assign is_last_o      = last_q;

endmodule

/* hw/rtl/data_uri_payload_decoder_top.sv */
// path: a combinational front end, the queue, then the registered output stage
// throughput: one input word per cycle while the queue is not full, one result
//   word per cycle while out_ready_i is high; the four-entry queue between the
//   character classifier and the byte emitter absorbs bursts, and a base64 group
//   (up to three bytes) drains at one byte per cycle while out_ready_i is high
// reset: rst_ni asynchronous active low clears the mode to percent decoding and
//   all stream state; the queue and output stage come up empty
`timescale 1ns / 1ps
module data_uri_payload_decoder_top import dupd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_char_i,
  input  logic       is_final_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       decode_error_o,
  output logic       is_last_o
);

  logic        push_valid, push_ready;
  dupd_entry_t push_entry;
  logic        head_valid, head_ready;
  dupd_entry_t head_entry;

  dupd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_char_i    (in_char_i),
    .is_final_i   (is_final_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  dupd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (push_valid),
    .in_ready_o  (push_ready),
    .in_entry_i  (push_entry),
    .out_valid_o (head_valid),
    .out_ready_i (head_ready),
    .out_entry_o (head_entry)
  );

  dupd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (head_valid),
    .in_ready_o     (head_ready),
    .in_entry_i     (head_entry),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .byte_valid_o   (byte_valid_o),
    .decode_error_o (decode_error_o),
    .is_last_o      (is_last_o)
  );

endmodule

/* hw/rtl/dupd_checker.sv */
`timescale 1ns / 1ps
module dupd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_we_i,
  input logic       cfg_wdata_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       byte_valid_o,
  input logic       decode_error_o,
  input logic       is_last_o
);

  logic mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) && $stable(is_last_o))
    else $error("output word changed while stalled");

  a_err_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && decode_error_o |-> !byte_valid_o && out_byte_o == 8'd0)
    else $error("error word carries a byte");

  a_err_b64_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && decode_error_o |-> mode_q)
    else $error("error reported in percent mode");

  // an empty non-error word only marks the end of a stream
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o && !decode_error_o |-> is_last_o && out_byte_o == 8'd0)
    else $error("empty word without end mark");

endmodule

bind data_uri_payload_decoder_top dupd_checker u_dupd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .cfg_we_i       (cfg_we_i),
  .cfg_wdata_i    (cfg_wdata_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .out_byte_o     (out_byte_o),
  .byte_valid_o   (byte_valid_o),
  .decode_error_o (decode_error_o),
  .is_last_o      (is_last_o)
);

/* sim/tb_data_uri_payload_decoder_top.sv */
`timescale 1ns / 1ps
module tb_data_uri_payload_decoder_top;
  import dupd_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int HoldAtWord = 14;
  localparam int HoldCycles = 120;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       decode_error;
    logic       is_last;
  } uri_word_t;

  typedef logic [7:0] char_q_t[$];

  // predicts the result words of the decoder and checks them in order
  class uri_decode_tracker;
    bit          mode;
    logic [17:0] acc;
    logic [1:0]  grp;
    logic [1:0]  pads;
    logic [1:0]  esc_phase;
    logic [3:0]  nib;
    bit          stopped;
    bit          failed;
    uri_word_t   pending_words[$];
    int          mismatches;
    int          words_checked;
    int          bytes_seen;
    int          errors_seen;

    function void clear_stream();
      acc       = '0;
      grp       = '0;
      pads      = '0;
      esc_phase = '0;
      nib       = '0;
      stopped   = 1'b0;
      failed    = 1'b0;
    endfunction

    function uri_word_t word_of(logic [7:0] b, logic v, logic e, logic l);
      uri_word_t w;
      w.data         = b;
      w.byte_valid   = v;
      w.decode_error = e;
      w.is_last      = l;
      return w;
    endfunction

    function int sextet_code(logic [7:0] c);
      if (c == CharPlus) return 62;
      if (c == CharSlash) return 63;
      if (c == CharPad) return 0;
      if (c >= 8'h30 && c <= 8'h39) return int'(c) + 4;
      if (c >= 8'h41 && c <= 8'h5a) return int'(c) - 65;
      if (c >= 8'h61 && c <= 8'h7a) return int'(c) - 71;
      return -1;
    endfunction

    function int hex_code(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      return -1;
    endfunction

    function bit blank(logic [7:0] c);
      return (c == CharSpace) || (c >= CharTab && c <= CharCr);
    endfunction

    // second escape character, strtol style
    function logic [7:0] escape_byte(logic [7:0] c);
      int d;
      d = hex_code(c);
      if (esc_phase == 2'd2) return (d < 0) ? {4'h0, nib} : {nib, 4'(d)};
      if (d < 0 || nib == 4'd0) return 8'h00;
      if (nib == 4'd2) return 8'(-d);
      return 8'(d);
    endfunction

    function void note_char(logic [7:0] c, bit fin);
      uri_word_t   words[$];
      uri_word_t   w;
      int          s;
      int          d;
      int          n;
      logic [23:0] full;
      bit          was_failed;
      if (mode) begin
        was_failed = failed;
        if (!failed && c != CharSpace) begin
          s = sextet_code(c);
          if (s < 0) begin
            failed = 1'b1;
            words.push_back(word_of(8'h00, 1'b0, 1'b1, 1'b0));
          end else begin
            if (c == CharPad && pads < 2'd3) pads++;
            if (grp < 2'd3) begin
              acc = {acc[11:0], 6'(s)};
              grp++;
            end else begin
              full = {acc, 6'(s)};
              for (int k = 0; k < 3 - int'(pads); k++) begin
                words.push_back(word_of(8'(full >> (16 - 8 * k)), 1'b1, 1'b0, 1'b0));
              end
              acc  = '0;
              grp  = '0;
              pads = '0;
            end
          end
        end
        if (fin) begin
          if (!failed && grp != 2'd0) failed = 1'b1;
          n = words.size();
          if (n > 0 && (!failed || (!was_failed && words[n-1].decode_error))) begin
            w = words[n-1];
            w.is_last = 1'b1;
            words[n-1] = w;
          end else begin
            words.push_back(word_of(8'h00, 1'b0, failed, 1'b1));
          end
        end
      end else begin
        if (esc_phase == 2'd1) begin
          d = hex_code(c);
          if (d >= 0) begin
            esc_phase = 2'd2;
            nib       = 4'(d);
          end else begin
            esc_phase = 2'd3;
            nib = (blank(c) || c == CharPlus) ? 4'd1 : ((c == CharMinus) ? 4'd2 : 4'd0);
          end
          // escape cut short: emit what was parsed so far
          if (fin) begin
            words.push_back(word_of((esc_phase == 2'd2) ? {4'h0, nib} : 8'h00,
                                    1'b1, 1'b0, 1'b0));
          end
        end else if (esc_phase >= 2'd2) begin
          words.push_back(word_of(escape_byte(c), 1'b1, 1'b0, 1'b0));
          esc_phase = 2'd0;
          nib       = 4'd0;
        end else if (!stopped) begin
          if (c == CharSlash) begin
            stopped = 1'b1;
          end else if (c == CharPercent) begin
            esc_phase = 2'd1;
            if (fin) words.push_back(word_of(8'h00, 1'b1, 1'b0, 1'b0));
          end else begin
            words.push_back(word_of(c, 1'b1, 1'b0, 1'b0));
          end
        end
        if (fin) begin
          n = words.size();
          if (n > 0) begin
            w = words[n-1];
            w.is_last = 1'b1;
            words[n-1] = w;
          end else begin
            words.push_back(word_of(8'h00, 1'b0, 1'b0, 1'b1));
          end
        end
      end
      if (fin) clear_stream();
      foreach (words[i]) pending_words.push_back(words[i]);
    endfunction

    function void check_word(logic [7:0] b, logic v, logic e, logic l);
      uri_word_t w;
      if (pending_words.size() == 0) begin
        $error("result word with nothing expected: out_byte %0h byte_valid %0b",
               b, v);
        mismatches++;
        return;
      end
      w = pending_words.pop_front();
      words_checked++;
      if (v) bytes_seen++;
      if (e) errors_seen++;
      if (b !== w.data) begin
        $error("out_byte: expected %0h, got %0h", w.data, b);
        mismatches++;
      end
      if (v !== w.byte_valid) begin
        $error("byte_valid: expected %0b, got %0b", w.byte_valid, v);
        mismatches++;
      end
      if (e !== w.decode_error) begin
        $error("decode_error: expected %0b, got %0b", w.decode_error, e);
        mismatches++;
      end
      if (l !== w.is_last) begin
        $error("is_last: expected %0b, got %0b", w.is_last, l);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_wdata;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_char;
  logic       is_final;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       decode_error;
  logic       is_last;

  uri_decode_tracker tracker;
  char_q_t           stream_q;
  int                cycle_count = 0;
  bit                no_idle = 1'b0;
  int                chars_sent = 0;
  int                streams_sent = 0;
  int                mode_writes = 0;

  data_uri_payload_decoder_top u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .in_char_i      (in_char),
    .is_final_i     (is_final),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .out_byte_o     (out_byte),
    .byte_valid_o   (byte_valid),
    .decode_error_o (decode_error),
    .is_last_o      (is_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("no progress after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [7:0] b64_symbol(int idx);
    if (idx < 26) return 8'(8'h41 + idx);
    if (idx < 52) return 8'(8'h61 + idx - 26);
    if (idx < 62) return 8'(8'h30 + idx - 52);
    return (idx == 62) ? CharPlus : CharSlash;
  endfunction

  function automatic logic [7:0] hex_symbol(int v);
    if (v < 10) return 8'(8'h30 + v);
    return ($urandom_range(0, 1) != 0) ? 8'(8'h41 + v - 10) : 8'(8'h61 + v - 10);
  endfunction

  // mostly whole groups with random symbols, some pads, spaces and junk
  function automatic void build_base64();
    int groups;
    int k;
    stream_q.delete();
    groups = $urandom_range(1, 4);
    for (int g = 0; g < groups; g++) begin
      for (int j = 0; j < 4; j++) begin
        if ($urandom_range(0, 7) == 0) stream_q.push_back(CharSpace);
        if ($urandom_range(0, 5) == 0) stream_q.push_back(CharPad);
        else stream_q.push_back(b64_symbol($urandom_range(0, 63)));
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      stream_q.insert($urandom_range(0, stream_q.size() - 1), 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 7) == 0) begin
      k = $urandom_range(1, 3);
      while (k > 0 && stream_q.size() > 1) begin
        void'(stream_q.pop_back());
        k--;
      end
    end
  endfunction

  function automatic void build_percent();
    int         tokens;
    logic [7:0] c;
    stream_q.delete();
    tokens = $urandom_range(1, 8);
    for (int t = 0; t < tokens; t++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          c = 8'($urandom_range(0, 255));
          if (c == CharSlash) c = CharPlus;
          stream_q.push_back(c);
        end
        5, 6: begin
          stream_q.push_back(CharPercent);
          stream_q.push_back(hex_symbol($urandom_range(0, 15)));
          stream_q.push_back(hex_symbol($urandom_range(0, 15)));
        end
        7: begin
          stream_q.push_back(CharPercent);
          case ($urandom_range(0, 4))
            0: stream_q.push_back(CharSpace);
            1: stream_q.push_back(CharTab);
            2: stream_q.push_back(CharPlus);
            3: stream_q.push_back(CharMinus);
            default: stream_q.push_back(8'($urandom_range(0, 255)));
          endcase
          stream_q.push_back(hex_symbol($urandom_range(0, 15)));
        end
        8: begin
          stream_q.push_back(CharPercent);
          stream_q.push_back(8'($urandom_range(0, 255)));
          stream_q.push_back(8'($urandom_range(0, 255)));
        end
        default: stream_q.push_back(CharSlash);
      endcase
    end
  endfunction

  task automatic write_mode(bit m);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we    <= 1'b0;
    tracker.mode = m;
    mode_writes++;
  endtask

  task automatic send_char(logic [7:0] c, bit fin);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_char  <= c;
    is_final <= fin;
    do @(posedge clk); while (!(in_valid && in_ready));
    tracker.note_char(c, fin);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(string s, bit ends);
    for (int i = 0; i < s.len(); i++) send_char(s[i], ends && (i == s.len() - 1));
    if (ends) streams_sent++;
  endtask

  task automatic send_stream(bit ends);
    foreach (stream_q[i]) send_char(stream_q[i], ends && (i == stream_q.size() - 1));
    if (ends) streams_sent++;
  endtask

  // inputs that give no word may still be in flight when the queue runs dry
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.pending_words.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin : receiver
    int stall;
    int n;
    stall     = 0;
    n         = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        tracker.check_word(out_byte, byte_valid, decode_error, is_last);
        n++;
        // one long hold so the input side backs up
        stall = (n == HoldAtWord) ? HoldCycles : (no_idle ? 0 : $urandom_range(0, 8));
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int  p;
    int  nstreams;
    bit  m;
    bit  ends;
    tracker   = new();
    tracker.clear_stream();
    tracker.mode = 1'b0;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    in_valid  = 1'b0;
    in_char   = 8'h00;
    is_final  = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // base64: pad inside a group, four pads, short final group, bad symbol
    write_mode(1'b1);
    send_text("/=+9", 1'b1);
    send_text("====", 1'b1);
    send_text("b", 1'b1);
    send_text("*z", 1'b1);
    wait_idle();

    // percent: extreme bytes, hex and '-' escapes, bad escape, stop, cut escape
    write_mode(1'b0);
    send_char(8'hff, 1'b0);
    send_text("%4f%-a%xy", 1'b0);
    send_char(8'h00, 1'b0);
    send_text("/q", 1'b1);
    send_text("%7", 1'b1);
    wait_idle();

    // back to back plain characters while the receiver holds off after the first word
    write_mode(1'b0);
    no_idle = 1'b1;
    for (int i = 0; i < 32; i++) send_char(8'(8'h61 + i % 26), i == 31);
    streams_sent++;
    no_idle = 1'b0;
    wait_idle();

    p = 0;
    while (chars_sent < 280) begin
      m = (p < 2) ? p[0] : 1'($urandom_range(0, 1));
      write_mode(m);
      no_idle  = (p % 5 == 4);
      nstreams = $urandom_range(1, 4);
      for (int s = 0; s < nstreams; s++) begin
        if (m) build_base64();
        else build_percent();
        // an open stream carries its state into the next mode
        ends = (s < nstreams - 1) || ($urandom_range(0, 4) != 0);
        send_stream(ends);
      end
      wait_idle();
      no_idle = 1'b0;
      p++;
    end

    if (tracker.pending_words.size() != 0) begin
      $error("%0d expected result words never arrived", tracker.pending_words.size());
      tracker.mismatches++;
    end
    $display("sent %0d characters, %0d closed streams, %0d mode writes",
             chars_sent, streams_sent, mode_writes);
    $display("checked %0d result words: %0d data bytes, %0d error flags",
             tracker.words_checked, tracker.bytes_seen, tracker.errors_seen);
    if (tracker.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
